### hdl/assert_macros.svh
// Assertion macros for the RTL of the button scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### hdl/mbdh_pkg.sv
// Types and constants of the multi-button debounce and hold scanner.
package mbdh_pkg;

    typedef enum logic [1:0] {
        MODE_RELEASED   = 2'd0,
        MODE_BOUNCE_ON  = 2'd1,
        MODE_ON         = 2'd2,
        MODE_BOUNCE_OFF = 2'd3
    } t_mode;

    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_ON_BOUNCE  = 3'd0;
    localparam logic [2:0] REG_OFF_BOUNCE = 3'd1;
    localparam logic [2:0] REG_LONG_HOLD  = 3'd2;
    localparam logic [2:0] REG_PRESS_EN   = 3'd3;
    localparam logic [2:0] REG_HOLD_EN    = 3'd4;
    localparam logic [2:0] REG_DOUBLE_EN  = 3'd5;

    localparam logic [7:0]  ON_BOUNCE_RESET  = 8'd3;
    localparam logic [7:0]  OFF_BOUNCE_RESET = 8'd3;
    localparam logic [15:0] LONG_HOLD_RESET  = 16'd50;

    typedef struct packed {
        logic [7:0]  on_bounce;
        logic [7:0]  off_bounce;
        logic [15:0] long_hold;
        logic [3:0]  press_en;
        logic [3:0]  hold_en;
        logic [3:0]  double_en;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  bounce;
        logic [15:0] hold;
        logic        down;
        logic        sticky_press;
        logic        sticky_hold;
        logic [7:0]  presses;
    } t_btn;

    localparam t_btn BTN_RESET = '{
        mode: MODE_RELEASED, bounce: 8'd0, hold: 16'd0, down: 1'b0,
        sticky_press: 1'b0, sticky_hold: 1'b0, presses: 8'd0
    };

    typedef struct packed {
        logic press;
        logic dbl;
        logic hold;
    } t_events;

endpackage

### hdl/mbdh_cfg_regs.sv
// Configuration register bank with an APB-style write and read port.
module mbdh_cfg_regs import mbdh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_bounce  <= ON_BOUNCE_RESET;
            r_cfg.off_bounce <= OFF_BOUNCE_RESET;
            r_cfg.long_hold  <= LONG_HOLD_RESET;
            r_cfg.press_en   <= 4'd0;
            r_cfg.hold_en    <= 4'd0;
            r_cfg.double_en  <= 4'd0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ON_BOUNCE:  r_cfg.on_bounce  <= pwdata[7:0];
                REG_OFF_BOUNCE: r_cfg.off_bounce <= pwdata[7:0];
                REG_LONG_HOLD:  r_cfg.long_hold  <= pwdata[15:0];
                REG_PRESS_EN:   r_cfg.press_en   <= pwdata[3:0];
                REG_HOLD_EN:    r_cfg.hold_en    <= pwdata[3:0];
                REG_DOUBLE_EN:  r_cfg.double_en  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ON_BOUNCE:  prdata = {24'd0, r_cfg.on_bounce};
            REG_OFF_BOUNCE: prdata = {24'd0, r_cfg.off_bounce};
            REG_LONG_HOLD:  prdata = {16'd0, r_cfg.long_hold};
            REG_PRESS_EN:   prdata = {28'd0, r_cfg.press_en};
            REG_HOLD_EN:    prdata = {28'd0, r_cfg.hold_en};
            REG_DOUBLE_EN:  prdata = {28'd0, r_cfg.double_en};
            default:        prdata = '0;
        endcase
    end

endmodule

### hdl/mbdh_btn_step.sv
// One scan step of a single button's debounce and hold state machine.
module mbdh_btn_step import mbdh_pkg::*; (
    input  t_btn        i_cur,
    input  logic        i_level,
    input  logic [7:0]  i_on_bounce,
    input  logic [7:0]  i_off_bounce,
    input  logic [15:0] i_long_hold,
    input  logic        i_press_en,
    input  logic        i_double_en,
    input  logic        i_hold_en,
    output t_btn        o_nxt,
    output t_events     o_ev
);

    function automatic logic [15:0] hold_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    t_mode       w_mode;
    logic [7:0]  w_bounce_inc;
    logic [15:0] w_hold_on;

    assign w_bounce_inc = i_cur.bounce + 8'd1;

    // Next mode.
    always_comb begin
        w_mode = i_cur.mode;
        case (i_cur.mode)
            MODE_RELEASED:   if (i_level) w_mode = MODE_BOUNCE_ON;
            MODE_BOUNCE_ON:  if (w_bounce_inc > i_on_bounce) w_mode = MODE_ON;
            MODE_ON:         if (!i_level) w_mode = MODE_BOUNCE_OFF;
            MODE_BOUNCE_OFF: if (i_cur.bounce > i_off_bounce) w_mode = MODE_RELEASED;
            default:         w_mode = i_cur.mode;
        endcase
    end

    // Counters, flags and events.
    always_comb begin
        o_nxt      = i_cur;
        o_nxt.mode = w_mode;
        o_ev       = '0;
        case (i_cur.mode)
            MODE_RELEASED: begin
                if (i_level) begin
                    o_ev.press         = i_press_en;
                    o_ev.dbl           = i_double_en && (i_cur.presses != 8'd0);
                    o_nxt.down         = 1'b1;
                    o_nxt.sticky_press = 1'b1;
                    if (i_cur.presses != 8'hFF) o_nxt.presses = i_cur.presses + 8'd1;
                end
            end
            MODE_BOUNCE_ON: begin
                o_nxt.hold   = hold_inc(i_cur.hold);
                o_nxt.bounce = (w_bounce_inc > i_on_bounce) ? 8'd0 : w_bounce_inc;
            end
            MODE_ON: begin
                if (!i_level) o_nxt.down = 1'b0;
            end
            MODE_BOUNCE_OFF: begin
                if (i_cur.bounce > i_off_bounce) begin
                    o_nxt.bounce = 8'd0;
                    o_nxt.hold   = 16'd0;
                end else begin
                    o_nxt.bounce = w_bounce_inc;
                end
            end
            default: ;
        endcase
        // While on, the hold counter runs and, past the limit, a long hold is reported each tick.
        w_hold_on = hold_inc(o_nxt.hold);
        if (w_mode == MODE_ON) begin
            o_nxt.hold = w_hold_on;
            if (w_hold_on > i_long_hold) begin
                o_nxt.sticky_hold = 1'b1;
                o_nxt.presses     = 8'd0;
                o_ev.hold         = i_hold_en;
            end
        end
    end

endmodule

### hdl/multi_button_debounce_hold_scanner.sv
// Top level of the time-multiplexed multi-button debounce and hold scanner.
//
// Usage: each request on the input channel is either a scan tick, which
// advances the round-robin index to the next button and runs that button's
// debounce machine on its sampled pin, or a clear of the selected button's
// flags and counters. Every request yields exactly one result request that
// carries the serviced button, the press, double-press and long-hold events
// (gated by the enable masks), the pressed, was-pressed and held maps and the
// counts of the selected button after the step.
// A request accepted at an edge waits in the input register; at the edge
// that moves it on, its result is written into the result register.
// Throughput is one request per cycle while the receiver does not stall;
// the work of a request is a single pass through one shared button step unit.
// A result that the receiver stalls stays in the result register. While it
// waits, a request held in the input register cannot move, so the input
// stall rises in the same cycle as the output stall once that register is full.
// Reset (synchronous, active low) empties both registers, puts every button
// in the released mode with zero counters and flags, sets the scan index to
// zero so the first tick serves button one, and loads the register defaults.
// Configuration is written through the APB-style port at byte address 4*i.
module multi_button_debounce_hold_scanner import mbdh_pkg::*; #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [3:0]            i_button_levels,
    input  logic [1:0]            i_button_select,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_serviced_button,
    output logic                  o_press_event,
    output logic                  o_double_event,
    output logic                  o_hold_event,
    output logic [3:0]            o_pressed_map,
    output logic [3:0]            o_was_pressed_map,
    output logic [3:0]            o_held_map,
    output logic [7:0]            o_selected_press_count,
    output logic [15:0]           o_selected_hold_time,
    output logic [15:0]           o_selected_excess_hold
);

`include "assert_macros.svh"

    localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam logic [IW-1:0] LAST_BUTTON = IW'(BUTTON_COUNT - 1);

    t_cfg w_cfg;

    mbdh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register.
    logic       r_in_valid;
    t_op        r_in_op;
    logic [3:0] r_in_levels;
    logic [1:0] r_in_sel;

    // Button state and scan index.
    t_btn          r_btn [BUTTON_COUNT];
    t_btn          n_btn [BUTTON_COUNT];
    logic [IW-1:0] r_scan;
    logic [IW-1:0] n_scan;

    // Result register.
    logic r_out_valid;
    logic [1:0]  r_served;
    t_events     r_ev;
    logic [3:0]  r_pm, r_wm, r_hm;
    logic [7:0]  r_cnt;
    logic [15:0] r_ht, r_ex;

    logic [1:0]  n_served;
    t_events     n_ev;
    logic [3:0]  n_pm, n_wm, n_hm;
    logic [7:0]  n_cnt;
    logic [15:0] n_ht, n_ex;

    logic          w_advance;
    logic          w_in_accept;
    logic [IW-1:0] w_b;
    logic [7:0]    w_b8;
    logic          w_b_low;
    logic          w_sel_ok;
    logic [IW-1:0] w_sel_idx;
    t_btn          w_step_nxt;
    t_events       w_step_ev;
    t_btn          w_sel_btn;

    // The input register moves into the result register whenever that one
    // is empty or being drained in the same cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Button served by a scan tick; buttons at four and above have no pin.
    assign w_b       = (r_scan == LAST_BUTTON) ? '0 : r_scan + 1'b1;
    assign w_b8      = 8'(w_b);
    assign w_b_low   = (w_b8 < 8'd4);
    assign w_sel_ok  = (32'(r_in_sel) < BUTTON_COUNT);
    assign w_sel_idx = IW'(r_in_sel);

    mbdh_btn_step u_step (
        .i_cur        (r_btn[w_b]),
        .i_level      (w_b_low && r_in_levels[w_b8[1:0]]),
        .i_on_bounce  (w_cfg.on_bounce),
        .i_off_bounce (w_cfg.off_bounce),
        .i_long_hold  (w_cfg.long_hold),
        .i_press_en   (w_b_low && w_cfg.press_en[w_b8[1:0]]),
        .i_double_en  (w_b_low && w_cfg.double_en[w_b8[1:0]]),
        .i_hold_en    (w_b_low && w_cfg.hold_en[w_b8[1:0]]),
        .o_nxt        (w_step_nxt),
        .o_ev         (w_step_ev)
    );

    // State update for the request in the input register.
    always_comb begin
        n_btn    = r_btn;
        n_scan   = r_scan;
        n_ev     = '0;
        n_served = r_in_sel;
        if (w_advance) begin
            if (r_in_op == OP_CLEAR) begin
                // A clear leaves the mode and bounce count alone.
                if (w_sel_ok) begin
                    n_btn[w_sel_idx].down         = 1'b0;
                    n_btn[w_sel_idx].sticky_press = 1'b0;
                    n_btn[w_sel_idx].sticky_hold  = 1'b0;
                    n_btn[w_sel_idx].hold         = 16'd0;
                    n_btn[w_sel_idx].presses      = 8'd0;
                end
            end else begin
                n_scan     = w_b;
                n_btn[w_b] = w_step_nxt;
                n_ev       = w_step_ev;
                n_served   = w_b8[1:0];
            end
        end
    end

    // Result fields, taken from the state after the update.
    always_comb begin
        n_pm = '0;
        n_wm = '0;
        n_hm = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < BUTTON_COUNT) begin
                n_pm[i] = n_btn[IW'(i)].down;
                n_wm[i] = n_btn[IW'(i)].sticky_press;
                n_hm[i] = n_btn[IW'(i)].sticky_hold;
            end
        end
        w_sel_btn = w_sel_ok ? n_btn[w_sel_idx] : BTN_RESET;
        n_cnt     = w_sel_btn.presses;
        n_ht      = w_sel_btn.hold;
        n_ex      = (n_ht > w_cfg.long_hold) ? n_ht - w_cfg.long_hold : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_btn[i] <= BTN_RESET;
            end
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_scan <= n_scan;
            r_btn  <= n_btn;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_op     <= t_op'(i_operation);
            r_in_levels <= i_button_levels;
            r_in_sel    <= i_button_select;
        end
        if (w_advance) begin
            r_served <= n_served;
            r_ev     <= n_ev;
            r_pm     <= n_pm;
            r_wm     <= n_wm;
            r_hm     <= n_hm;
            r_cnt    <= n_cnt;
            r_ht     <= n_ht;
            r_ex     <= n_ex;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_serviced_button      = r_served;
    assign o_press_event          = r_ev.press;
    assign o_double_event         = r_ev.dbl;
    assign o_hold_event           = r_ev.hold;
    assign o_pressed_map          = r_pm;
    assign o_was_pressed_map      = r_wm;
    assign o_held_map             = r_hm;
    assign o_selected_press_count = r_cnt;
    assign o_selected_hold_time   = r_ht;
    assign o_selected_excess_hold = r_ex;

    // The scan index always names a button that exists.
    `ASSERT_RST(a_scan_in_range, i_clk, i_rst_n, 32'(r_scan) < BUTTON_COUNT)
    // The index moves only when a request leaves the input register.
    `ASSERT_RST(a_scan_holds_idle, i_clk, i_rst_n, !w_advance |=> $stable(r_scan))
    // A clear never moves the scan index.
    `ASSERT_RST(a_clear_keeps_scan, i_clk, i_rst_n,
        (w_advance && r_in_op == OP_CLEAR) |=> $stable(r_scan))
    // A request that leaves the input register always shows up as a result.
    `ASSERT_RST(a_advance_gives_result, i_clk, i_rst_n, w_advance |=> r_out_valid)

endmodule

### bench/multi_button_debounce_hold_scanner_tb.sv
// Self-checking testbench of the multi-button debounce and hold scanner.
module multi_button_debounce_hold_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbdh_pkg::*;

    // The block is built for a bank of four buttons, which fills the 4-bit
    // pin and map fields exactly.
    localparam int BUTTONS = 4;

    // The watchdog limit lies far above the length of a correct run.
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // The pause before a register write and at the end of the run, after
    // every predicted result has come back, lets the block settle.
    localparam int SETTLE_CYCLES = 4;

    // One result request of the block, field by field.
    typedef struct packed {
        logic [1:0]  serviced;
        logic        press;
        logic        dbl;
        logic        hold;
        logic [3:0]  pressed;
        logic [3:0]  was_pressed;
        logic [3:0]  held;
        logic [7:0]  count;
        logic [15:0] hold_time;
        logic [15:0] excess;
    } t_scan_report;

    // The scoreboard keeps its own copy of the registers and of every
    // button's debounce state. For each accepted request it works out the
    // result that the block has to return, and it checks the returned
    // results in order against those predictions.
    class button_bank_scoreboard;
        t_cfg         regs;
        int           scan_pos;
        t_btn         bank [BUTTONS];
        t_scan_report due_reports [$];
        int           mismatches;

        function new();
            regs            = '0;
            regs.on_bounce  = ON_BOUNCE_RESET;
            regs.off_bounce = OFF_BOUNCE_RESET;
            regs.long_hold  = LONG_HOLD_RESET;
            scan_pos        = 0;
            foreach (bank[i]) bank[i] = BTN_RESET;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ON_BOUNCE:  regs.on_bounce  = val[7:0];
                REG_OFF_BOUNCE: regs.off_bounce = val[7:0];
                REG_LONG_HOLD:  regs.long_hold  = val[15:0];
                REG_PRESS_EN:   regs.press_en   = val[3:0];
                REG_HOLD_EN:    regs.hold_en    = val[3:0];
                REG_DOUBLE_EN:  regs.double_en  = val[3:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] sat_inc(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void note_request(t_op op, logic [3:0] levels, logic [1:0] sel);
            t_scan_report r;
            int           b;
            r          = '0;
            r.serviced = sel;
            if (op == OP_CLEAR) begin
                // A clear leaves the mode and the scan position alone.
                if (sel < BUTTONS) begin
                    bank[sel].down         = 1'b0;
                    bank[sel].sticky_press = 1'b0;
                    bank[sel].sticky_hold  = 1'b0;
                    bank[sel].hold         = '0;
                    bank[sel].presses      = '0;
                end
            end else begin
                b = scan_pos + 1;
                if (b >= BUTTONS) b = 0;
                scan_pos   = b;
                r.serviced = 2'(b);
                case (bank[b].mode)
                    MODE_RELEASED: begin
                        if (levels[b]) begin
                            r.press = regs.press_en[b];
                            r.dbl   = regs.double_en[b] & (bank[b].presses != 8'd0);
                            bank[b].down         = 1'b1;
                            bank[b].sticky_press = 1'b1;
                            if (bank[b].presses != 8'hFF)
                                bank[b].presses = bank[b].presses + 8'd1;
                            bank[b].mode = MODE_BOUNCE_ON;
                        end
                    end
                    MODE_BOUNCE_ON: begin
                        bank[b].bounce = bank[b].bounce + 8'd1;
                        bank[b].hold   = sat_inc(bank[b].hold);
                        if (bank[b].bounce > regs.on_bounce) begin
                            bank[b].bounce = '0;
                            bank[b].mode   = MODE_ON;
                        end
                    end
                    MODE_ON: begin
                        if (!levels[b]) begin
                            bank[b].down = 1'b0;
                            bank[b].mode = MODE_BOUNCE_OFF;
                        end
                    end
                    default: begin
                        // The bounce count is compared before it moves, so an
                        // off count of 255 never lets the button go.
                        if (bank[b].bounce > regs.off_bounce) begin
                            bank[b].bounce = '0;
                            bank[b].hold   = '0;
                            bank[b].mode   = MODE_RELEASED;
                        end else begin
                            bank[b].bounce = bank[b].bounce + 8'd1;
                        end
                    end
                endcase
                // Every button in on mode gets a hold tick here, a second one if it just left bounce-on.
                if (bank[b].mode == MODE_ON) begin
                    bank[b].hold = sat_inc(bank[b].hold);
                    if (bank[b].hold > regs.long_hold) begin
                        bank[b].sticky_hold = 1'b1;
                        bank[b].presses     = '0;
                        r.hold              = regs.hold_en[b];
                    end
                end
            end
            for (int i = 0; i < BUTTONS; i++) begin
                r.pressed[i]     = bank[i].down;
                r.was_pressed[i] = bank[i].sticky_press;
                r.held[i]        = bank[i].sticky_hold;
            end
            if (sel < BUTTONS) begin
                r.count     = bank[sel].presses;
                r.hold_time = bank[sel].hold;
                r.excess    = (r.hold_time > regs.long_hold) ?
                              r.hold_time - regs.long_hold : '0;
            end
            due_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%s differs: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_report(t_scan_report got);
            t_scan_report want;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result for button %0d arrived with none expected",
                             got.serviced);
                return;
            end
            want = due_reports.pop_front();
            check_field("serviced_button", 16'(want.serviced), 16'(got.serviced));
            check_field("press_event", 16'(want.press), 16'(got.press));
            check_field("double_event", 16'(want.dbl), 16'(got.dbl));
            check_field("hold_event", 16'(want.hold), 16'(got.hold));
            check_field("pressed_map", 16'(want.pressed), 16'(got.pressed));
            check_field("was_pressed_map", 16'(want.was_pressed), 16'(got.was_pressed));
            check_field("held_map", 16'(want.held), 16'(got.held));
            check_field("selected_press_count", 16'(want.count), 16'(got.count));
            check_field("selected_hold_time", want.hold_time, got.hold_time);
            check_field("selected_excess_hold", want.excess, got.excess);
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic                  in_valid  = 1'b0;
    t_op                   in_op     = OP_SCAN;
    logic [3:0]            in_levels = '0;
    logic [1:0]            in_sel    = '0;
    logic                  out_stall = 1'b0;

    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_serviced_button;
    logic                  o_press_event;
    logic                  o_double_event;
    logic                  o_hold_event;
    logic [3:0]            o_pressed_map;
    logic [3:0]            o_was_pressed_map;
    logic [3:0]            o_held_map;
    logic [7:0]            o_selected_press_count;
    logic [15:0]           o_selected_hold_time;
    logic [15:0]           o_selected_excess_hold;

    // While calm is set, neither side idles or stalls, which gives the long
    // stretch at full rate.
    bit                    calm = 1'b0;
    int unsigned           cycle_count = 0;

    button_bank_scoreboard sb = new();

    multi_button_debounce_hold_scanner #(
        .BUTTON_COUNT(BUTTONS)
    ) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .i_in_valid             (in_valid),
        .o_in_stall             (o_in_stall),
        .i_operation            (in_op),
        .i_button_levels        (in_levels),
        .i_button_select        (in_sel),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (out_stall),
        .o_serviced_button      (o_serviced_button),
        .o_press_event          (o_press_event),
        .o_double_event         (o_double_event),
        .o_hold_event           (o_hold_event),
        .o_pressed_map          (o_pressed_map),
        .o_was_pressed_map      (o_was_pressed_map),
        .o_held_map             (o_held_map),
        .o_selected_press_count (o_selected_press_count),
        .o_selected_hold_time   (o_selected_hold_time),
        .o_selected_excess_hold (o_selected_excess_hold)
    );

    always #2 i_clk = ~i_clk;

    // About a third of the cycles are idle on each side, except when calm.
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Result side. Everything here is sampled at the rising edge, before the
    // block's registers update, so the values seen are the ones that decide
    // the handshake at this edge. The stall for the next cycle is then
    // chosen at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_report(t_scan_report'{
                serviced:    o_serviced_button,
                press:       o_press_event,
                dbl:         o_double_event,
                hold:        o_hold_event,
                pressed:     o_pressed_map,
                was_pressed: o_was_pressed_map,
                held:        o_held_map,
                count:       o_selected_press_count,
                hold_time:   o_selected_hold_time,
                excess:      o_selected_excess_hold
            });
        out_stall <= take_break();
    end

    // Watchdog: a run that hangs ends here as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one request, after a random number of idle cycles, and holds it
    // steady until the block takes it. Returns in the time step of the edge
    // that accepted it, with valid still high, so the next call can follow
    // back to back.
    task automatic send_request(t_op op, logic [3:0] levels, logic [1:0] sel);
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_op     <= op;
        in_levels <= levels;
        in_sel    <= sel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(op, levels, sel);
    endtask

    // Drops valid and waits until every predicted result has come back,
    // then lets the pipeline settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A register write: setup cycle, then the access cycle, which completes
    // at the edge where pready is seen high. The bus then goes back to idle.
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Registers are only touched once the block has gone quiet.
    task automatic configure(logic [7:0] on_ticks, logic [7:0] off_ticks,
                             logic [15:0] hold_limit, logic [3:0] press_mask,
                             logic [3:0] hold_mask, logic [3:0] double_mask);
        wait_drained();
        apb_write(REG_ON_BOUNCE, 32'(on_ticks));
        apb_write(REG_OFF_BOUNCE, 32'(off_ticks));
        apb_write(REG_LONG_HOLD, 32'(hold_limit));
        apb_write(REG_PRESS_EN, 32'(press_mask));
        apb_write(REG_HOLD_EN, 32'(hold_mask));
        apb_write(REG_DOUBLE_EN, 32'(double_mask));
    endtask

    // Random traffic that still looks like real buttons: each pin holds its
    // level for a while and flips now and then, so presses run through
    // bounce, on and long hold. A tenth of the scans carry random pin noise
    // and a few requests are clears.
    task automatic run_mixed(int count);
        logic [3:0] intent;
        logic [3:0] lv;
        intent = '0;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++)
                if ($urandom_range(29) == 0) intent[k] = ~intent[k];
            lv = ($urandom_range(9) == 0) ? 4'($urandom) : intent;
            if ($urandom_range(99) < 5)
                send_request(OP_CLEAR, 4'($urandom), 2'($urandom));
            else
                send_request(OP_SCAN, lv, 2'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: a clear and a press while every event is masked.
        send_request(OP_CLEAR, 4'hF, 2'd2);
        send_request(OP_SCAN, 4'hF, 2'd3);

        // Short bounce, a low hold limit and every event enabled. All pins
        // go down for three services per button, up for two, and down for
        // two more, which gives a press, a release and then a double press.
        configure(8'd1, 8'd0, 16'd6, 4'hF, 4'hF, 4'hF);
        for (int n = 0; n < 12; n++) send_request(OP_SCAN, 4'hF, 2'(n));
        for (int n = 0; n < 8; n++) send_request(OP_SCAN, 4'h0, 2'(n));
        for (int n = 0; n < 8; n++) send_request(OP_SCAN, 4'hF, 2'(n));
        send_request(OP_CLEAR, 4'h0, 2'd0);
        send_request(OP_CLEAR, 4'hF, 2'd3);

        // With an off count of 255 the release never completes and the
        // bounce counter keeps climbing; lowering the register lets the
        // buttons go.
        configure(8'd0, 8'd255, 16'hFFFF, 4'($urandom), 4'($urandom), 4'($urandom));
        repeat (12) send_request(OP_SCAN, 4'hF, 2'($urandom));
        repeat (40) send_request(OP_SCAN, 4'h0, 2'($urandom));
        configure(8'd0, 8'd2, 16'hFFFF, 4'($urandom), 4'($urandom), 4'($urandom));
        repeat (24) send_request(OP_SCAN, 4'h0, 2'($urandom));

        // Quick press cycles with the hold limit at its top, so no long hold
        // resets the press count and every press after the first is a double,
        // at full rate on both sides.
        configure(8'd0, 8'd0, 16'hFFFF, 4'hF, 4'hF, 4'hF);
        calm = 1'b1;
        repeat (20) begin
            repeat (8) send_request(OP_SCAN, 4'hF, 2'($urandom));
            repeat (12) send_request(OP_SCAN, 4'h0, 2'($urandom));
        end
        calm = 1'b0;

        // Random traffic, first with the lowest settings and every event
        // enabled, then under random small settings and masks.
        configure(8'd0, 8'd0, 16'd0, 4'hF, 4'hF, 4'hF);
        run_mixed(160);
        repeat (5) begin
            configure(8'($urandom_range(4)), 8'($urandom_range(4)),
                      16'($urandom_range(15)), 4'($urandom), 4'($urandom),
                      4'($urandom));
            run_mixed(160);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/mbdh_pkg.sv
hdl/mbdh_cfg_regs.sv
hdl/mbdh_btn_step.sv
hdl/multi_button_debounce_hold_scanner.sv
bench/multi_button_debounce_hold_scanner_tb.sv
